// ===== rtl/core/assert_macros.svh =====
// assertion macros shared by the timestamp range normalizer modules
// no dependencies; included by the files that carry assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled while in reset
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/core/tsn_pkg.sv =====
// types and constants of the timestamp range normalizer
// no dependencies; used by the controller, datapath and top level
package tsn_pkg;

    localparam int STAMP_W     = 32;
    localparam int MAG_W       = STAMP_W + 1;
    localparam int ACC_W       = STAMP_W + 4;
    localparam int GAIN_W      = 48;
    localparam int GAIN_SPLIT  = 24;
    localparam int MUL_W       = MAG_W + GAIN_SPLIT;
    localparam int GAIN_SHIFT  = 31;
    localparam int A_LIMIT_BIT = 39;
    localparam int SUM_W       = 64;
    localparam int Q_W         = 34;
    localparam int CFG_IDX_W   = 4;
    localparam int METHOD_W    = 2;

    localparam logic [GAIN_W-1:0]  UNITY_GAIN = GAIN_W'(1) << GAIN_SHIFT;
    localparam logic [Q_W-1:0]     SCALED_CAP = Q_W'(1) << 33;
    localparam logic [STAMP_W-1:0] STAMP_MAX  = {1'b0, {(STAMP_W-1){1'b1}}};
    localparam logic [STAMP_W-1:0] STAMP_MIN  = {1'b1, {(STAMP_W-1){1'b0}}};

    localparam logic [METHOD_W-1:0] METHOD_MID  = 2'd0;
    localparam logic [METHOD_W-1:0] METHOD_MIN  = 2'd1;
    localparam logic [METHOD_W-1:0] METHOD_UNIT = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_METHOD = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET = 4'd1;

    localparam logic FUNC_MEASURE = 1'b0;
    localparam logic FUNC_ADJUST  = 1'b1;

    typedef struct packed {
        logic measure;
        logic latch_adjust;
        logic set_base;
        logic do_diff;
        logic div_start;
        logic div_step;
        logic do_mul;
        logic do_scale;
        logic do_offs;
        logic load_out;
    } tsn_cmd_t;

    typedef struct packed {
        logic range_valid;
        logic gain_ready;
        logic method_unit;
        logic div_last;
        logic out_free;
    } tsn_stat_t;

endpackage

// ===== rtl/core/tsn_ctrl.sv =====
// sequencer of the timestamp range normalizer
// depends on tsn_pkg and assert_macros.svh; drives the datapath commands
`include "assert_macros.svh"

module tsn_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic               func,
    input  tsn_pkg::tsn_stat_t stat,
    output tsn_pkg::tsn_cmd_t  cmd
);
    import tsn_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_BASE  = 3'd1;
    localparam logic [2:0] ST_DIFF  = 3'd2;
    localparam logic [2:0] ST_DIV   = 3'd3;
    localparam logic [2:0] ST_MUL   = 3'd4;
    localparam logic [2:0] ST_SCALE = 3'd5;
    localparam logic [2:0] ST_OFFS  = 3'd6;
    localparam logic [2:0] ST_OUT   = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       accept;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid & s_tready;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (func == FUNC_MEASURE)
                    begin
                        cmd.measure = 1'b1;
                    end
                    else
                    begin
                        cmd.latch_adjust = 1'b1;
                        state_next = stat.range_valid ? ST_BASE : ST_OUT;
                    end
                end
            end
            ST_BASE:
            begin
                cmd.set_base = 1'b1;
                state_next   = ST_DIFF;
            end
            ST_DIFF:
            begin
                cmd.do_diff = 1'b1;
                if (!stat.method_unit)
                begin
                    state_next = ST_OUT;
                end
                else if (stat.gain_ready)
                begin
                    state_next = ST_MUL;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.do_mul = 1'b1;
                state_next = ST_SCALE;
            end
            ST_SCALE:
            begin
                cmd.do_scale = 1'b1;
                state_next   = ST_OFFS;
            end
            ST_OFFS:
            begin
                cmd.do_offs = 1'b1;
                state_next  = ST_OUT;
            end
            ST_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    `ASSERT_NXT(a_div_holds, clk, rst_n, (state_reg == ST_DIV) && !stat.div_last, state_reg == ST_DIV)
    `ASSERT_NXT(a_err_direct, clk, rst_n, accept && (func == FUNC_ADJUST) && !stat.range_valid, state_reg == ST_OUT)
    `ASSERT_NXT(a_out_done, clk, rst_n, (state_reg == ST_OUT) && stat.out_free, state_reg == ST_IDLE)

endmodule

// ===== rtl/core/tsn_datapath.sv =====
// datapath of the timestamp range normalizer: extremes, config, divider, scaler
// depends on tsn_pkg and assert_macros.svh; steered by tsn_ctrl
`include "assert_macros.svh"

module tsn_datapath #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  tsn_pkg::tsn_cmd_t                   cmd,
    output tsn_pkg::tsn_stat_t                  stat,
    input  logic                                first_of_cloud,
    input  logic [tsn_pkg::STAMP_W-1:0]         stamp,
    input  logic                                cfg_we,
    input  logic [tsn_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [tsn_pkg::STAMP_W-1:0]         cfg_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [tsn_pkg::STAMP_W-1:0]         out_stamp,
    output logic                                out_err
);
    import tsn_pkg::*;

    localparam int DIV_N = FRAC_BITS + STAMP_W;
    localparam int CNT_W = $clog2(DIV_N);

    logic [METHOD_W-1:0] method_reg;
    logic [STAMP_W-1:0]  offset_reg;
    logic                range_valid_reg;
    logic                gain_ready_reg;
    logic                out_valid_reg;

    logic [STAMP_W-1:0]  min_reg;
    logic [STAMP_W-1:0]  max_reg;
    logic [STAMP_W-1:0]  t_reg;
    logic                err_reg;
    logic [STAMP_W-1:0]  base_reg;
    logic [ACC_W-1:0]    acc_reg;
    logic [MAG_W-1:0]    mag_reg;
    logic                neg_reg;
    logic [STAMP_W-1:0]  rem_reg;
    logic [GAIN_W-1:0]   quo_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [GAIN_W-1:0]   gain_reg;
    logic [MUL_W-1:0]    a_reg;
    logic [MUL_W-1:0]    b_reg;
    logic [Q_W-1:0]      q_reg;
    logic [STAMP_W-1:0]  out_stamp_reg;
    logic                out_err_reg;

    logic                method_unit;
    logic                use_min;
    logic [STAMP_W:0]    range_full;
    logic [STAMP_W-1:0]  range_r;
    logic [STAMP_W:0]    mid_sum;
    logic [STAMP_W-1:0]  base_next;
    logic [STAMP_W:0]    d;
    logic [MAG_W-1:0]    mag_next;
    logic [ACC_W-1:0]    off_ext;
    logic                div_bit;
    logic [STAMP_W:0]    sh;
    logic                ge;
    logic [STAMP_W:0]    sh_sub;
    logic [GAIN_W-1:0]   quo_next;
    logic                div_last;
    logic [MUL_W-1:0]    a_next;
    logic [MUL_W-1:0]    b_next;
    logic [SUM_W-1:0]    sum;
    logic [Q_W-1:0]      s_sh;
    logic [Q_W-1:0]      q_next;
    logic [ACC_W-1:0]    sq;
    logic                fits;
    logic [STAMP_W-1:0]  sat;
    logic                new_range;

    assign method_unit = (method_reg == METHOD_UNIT);
    assign use_min     = (method_reg == METHOD_MIN) || (method_reg == METHOD_UNIT);

    // unsigned spread of the extremes
    assign range_full = {max_reg[STAMP_W-1], max_reg} - {min_reg[STAMP_W-1], min_reg};
    assign range_r    = range_full[STAMP_W-1:0];
    assign mid_sum    = {min_reg[STAMP_W-1], min_reg} + {2'b00, range_r[STAMP_W-1:1]};
    assign base_next  = use_min ? min_reg : mid_sum[STAMP_W-1:0];

    assign d        = {t_reg[STAMP_W-1], t_reg} - {base_reg[STAMP_W-1], base_reg};
    assign mag_next = d[STAMP_W] ? (~d + MAG_W'(1)) : d;
    assign off_ext  = {{(ACC_W-STAMP_W){offset_reg[STAMP_W-1]}}, offset_reg};

    // restoring divider, dividend is a single one at its top bit
    assign div_bit  = (cnt_reg == '0);
    assign sh       = {rem_reg, div_bit};
    assign ge       = (sh >= {1'b0, range_r});
    assign sh_sub   = sh - {1'b0, range_r};
    assign quo_next = {quo_reg[GAIN_W-2:0], ge};
    assign div_last = (cnt_reg == CNT_W'(DIV_N - 1));

    assign a_next = {{GAIN_SPLIT{1'b0}}, mag_reg}
                  * {{MAG_W{1'b0}}, gain_reg[GAIN_W-1:GAIN_SPLIT]};
    assign b_next = {{GAIN_SPLIT{1'b0}}, mag_reg}
                  * {{MAG_W{1'b0}}, gain_reg[GAIN_SPLIT-1:0]};

    assign sum  = {1'b0, a_reg[A_LIMIT_BIT-1:0], {GAIN_SPLIT{1'b0}}}
                + {{(SUM_W-MUL_W){1'b0}}, b_reg};
    assign s_sh = {1'b0, sum[SUM_W-1:GAIN_SHIFT]};

    always_comb
    begin
        if (|a_reg[MUL_W-1:A_LIMIT_BIT])
        begin
            q_next = SCALED_CAP;
        end
        else if (s_sh > SCALED_CAP)
        begin
            q_next = SCALED_CAP;
        end
        else
        begin
            q_next = s_sh;
        end
    end

    assign sq = neg_reg ? (~{{(ACC_W-Q_W){1'b0}}, q_reg} + ACC_W'(1))
                        : {{(ACC_W-Q_W){1'b0}}, q_reg};

    // saturate the accumulator to the stamp width
    assign fits = (&acc_reg[ACC_W-1:STAMP_W-1]) || !(|acc_reg[ACC_W-1:STAMP_W-1]);
    always_comb
    begin
        if (fits)
        begin
            sat = acc_reg[STAMP_W-1:0];
        end
        else if (acc_reg[ACC_W-1])
        begin
            sat = STAMP_MIN;
        end
        else
        begin
            sat = STAMP_MAX;
        end
    end

    assign new_range = first_of_cloud || !range_valid_reg;

    // control and configuration state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            method_reg      <= METHOD_MID;
            offset_reg      <= '0;
            range_valid_reg <= 1'b0;
            gain_ready_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_METHOD: method_reg <= cfg_data[METHOD_W-1:0];
                    REG_OFFSET: offset_reg <= cfg_data;
                    default:    ;
                endcase
            end
            if (cmd.measure)
            begin
                range_valid_reg <= 1'b1;
                gain_ready_reg  <= 1'b0;
            end
            else if (cmd.div_step && div_last)
            begin
                gain_ready_reg <= 1'b1;
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (cmd.measure)
        begin
            if (new_range || ($signed(stamp) < $signed(min_reg)))
            begin
                min_reg <= stamp;
            end
            if (new_range || ($signed(stamp) > $signed(max_reg)))
            begin
                max_reg <= stamp;
            end
        end
        if (cmd.latch_adjust)
        begin
            t_reg   <= stamp;
            err_reg <= !range_valid_reg;
        end
        if (cmd.set_base)
        begin
            base_reg <= base_next;
        end
        if (cmd.do_diff)
        begin
            mag_reg <= mag_next;
            neg_reg <= d[STAMP_W];
            acc_reg <= {{(ACC_W-STAMP_W-1){d[STAMP_W]}}, d} - off_ext;
        end
        if (cmd.div_start)
        begin
            rem_reg <= '0;
            quo_reg <= '0;
            cnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= ge ? sh_sub[STAMP_W-1:0] : sh[STAMP_W-1:0];
            quo_reg <= quo_next;
            cnt_reg <= cnt_reg + CNT_W'(1);
            if (div_last)
            begin
                gain_reg <= (range_r == '0) ? UNITY_GAIN : quo_next;
            end
        end
        if (cmd.do_mul)
        begin
            a_reg <= a_next;
            b_reg <= b_next;
        end
        if (cmd.do_scale)
        begin
            q_reg <= q_next;
        end
        if (cmd.do_offs)
        begin
            acc_reg <= sq + off_ext;
        end
        if (cmd.load_out)
        begin
            out_stamp_reg <= err_reg ? '0 : sat;
            out_err_reg   <= err_reg;
        end
    end

    assign stat.range_valid = range_valid_reg;
    assign stat.gain_ready  = gain_ready_reg;
    assign stat.method_unit = method_unit;
    assign stat.div_last    = div_last;
    assign stat.out_free    = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_stamp = out_stamp_reg;
    assign out_err   = out_err_reg;

    `ASSERT_IMP(a_gain_from_div, clk, rst_n, $rose(gain_ready_reg), $past(cmd.div_step))
    `ASSERT_NXT(a_measure_drops_gain, clk, rst_n, cmd.measure, !gain_ready_reg && range_valid_reg)
    `ASSERT_NXT(a_err_zero, clk, rst_n, cmd.load_out && err_reg, out_err_reg && (out_stamp_reg == '0))

endmodule

// ===== rtl/core/timestamp_range_normalizer_top.sv =====
// top level of the timestamp range normalizer
// depends on tsn_pkg, tsn_ctrl and tsn_datapath

// Re-bases point timestamps (signed Q15.16) in two passes: measure words
// (s_tuser[0] = 0) track the cloud's extremes and return nothing, adjust words
// (s_tuser[0] = 1) return one saturated result each. The block works on one
// word at a time, stepping a shared datapath: measure words end in idle, adjust
// words before any measure go straight to the output state, methods 0 and 1
// form a base and a difference, the unit-range method also multiplies, scales
// and adds the offset, and on its first adjust word after a measure a restoring
// divider first forms the range reciprocal one quotient bit per cycle. A result
// waiting in the output register holds the block in its output state.
module timestamp_range_normalizer_top #(
    parameter int FRAC_BITS = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [tsn_pkg::STAMP_W-1:0]    s_tdata,   // stamp
    input  logic [1:0]                     s_tuser,   // func, first_of_cloud
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [tsn_pkg::STAMP_W-1:0]    m_tdata,   // adjusted_stamp
    output logic                           m_tuser,   // no_range_error
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [tsn_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tsn_pkg::STAMP_W-1:0]    cfg_data
);
    import tsn_pkg::*;

    tsn_cmd_t  cmd;
    tsn_stat_t stat;
    logic      cfg_we;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid & cfg_ready;

    tsn_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .func     (s_tuser[0]),
        .stat     (stat),
        .cmd      (cmd)
    );

    tsn_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .first_of_cloud (s_tuser[1]),
        .stamp          (s_tdata),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .out_stamp      (m_tdata),
        .out_err        (m_tuser)
    );

endmodule
